// ===== rtl/core/qlts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlts_pkg: shared types and constants
// Opcodes, register indexes, field widths and state encodings for the
// query likelihood top-K scanner.
// ----------------------------------------------------------------------------
package qlts_pkg;

  localparam int TopkDepthDef     = 64;
  localparam int MaxQueryTermsDef = 16;

  // input opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TOKEN = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;   // unused code, item is ignored

  // configuration register indexes
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_CUTOFF = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MU     = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_TOTAL  = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_TERMS  = 8'd3;

  // widths
  localparam int TweetW = 63;
  localparam int ScoreW = 32;
  localparam int RankW  = 11;
  localparam int LnXW   = 50;   // widest log argument: mu*(cf+1) + tf*(total+1)
  localparam int LnRW   = 38;   // ln() result, unsigned Q.32
  localparam int SumW   = 48;   // signed Q.32 accumulator
  localparam int MemW   = ScoreW + TweetW;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_NORM,
    LN_SQ,
    LN_MUL
  } ln_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LNMU,
    ST_LNLEN,
    ST_SLOT,
    ST_ADD,
    ST_LNA,
    ST_LNB,
    ST_ROUND,
    ST_KSCAN,
    ST_DSCAN,
    ST_DWAIT
  } state_t;

endpackage

// ===== rtl/core/query_likelihood_topk_scan_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_likelihood_topk_scan_top: Dirichlet query likelihood scan, top-K
// Scores streamed documents against a small query and keeps the best K.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes cutoff, mu,
//   collection size and term count; write only while the block is idle.
//   Input channel (in_valid/in_ready) takes load, token and drain items.
//   Output channel (out_valid/out_ready) returns drained results.
// Sequencing:
//   Load and plain token items: accepted one per cycle, back to back, while idle.
//   Last token of a scored document: each log runs in the shared log unit
//   (bit-serial normalize, 24 squarings, scale); two logs for the length
//   term plus two per hit query slot, with each query slot visited in turn,
//   a setup step per hit slot and a final rounding step. With the store full
//   and a positive score, a min scan of the whole store follows.
//   Drain of n results: each result needs a scan of the n kept entries
//   (one read port), then waits until its transfer completes.
// Reset: sets config registers to defaults, clears state, hit counts and the
//   kept count; the store itself needs no clearing. A stalled receiver holds the drain at that result.
// ----------------------------------------------------------------------------
module query_likelihood_topk_scan_top #(
  parameter int TOPK_DEPTH      = qlts_pkg::TopkDepthDef,
  parameter int MAX_QUERY_TERMS = qlts_pkg::MaxQueryTermsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qlts_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [63:0]                   cfg_data,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic [3:0]                    slot,
  input  logic [23:0]                   term_id,
  input  logic [31:0]                   collection_freq,
  input  logic [qlts_pkg::TweetW-1:0]   tweet_id,
  input  logic [7:0]                    doc_length,
  input  logic                          last_token,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qlts_pkg::TweetW-1:0]   result_tweet,
  output logic signed [qlts_pkg::ScoreW-1:0] result_score,
  output logic [qlts_pkg::RankW-1:0]    rank,
  output logic                          last_result
);

  localparam int AW = (TOPK_DEPTH > 1) ? $clog2(TOPK_DEPTH) : 1;
  localparam int CW = $clog2(TOPK_DEPTH + 1);
  localparam int QW = (MAX_QUERY_TERMS > 1) ? $clog2(MAX_QUERY_TERMS) : 1;
  localparam int NW = $clog2(MAX_QUERY_TERMS + 1);
  localparam int SW = qlts_pkg::SumW;

  // configuration registers
  logic [62:0] time_cutoff;
  logic [15:0] smoothing_mu;
  logic [39:0] collection_terms;
  logic [4:0]  term_count;

  // query table and per-slot hit counts
  logic [23:0] q_term [MAX_QUERY_TERMS];
  logic [31:0] q_freq [MAX_QUERY_TERMS];
  logic [7:0]  hit    [MAX_QUERY_TERMS];

  qlts_pkg::state_t state, state_next;

  logic [CW-1:0] kept;
  logic [CW-1:0] cnt;       // entries being drained
  logic [CW-1:0] r;         // results sent in this drain
  logic [TOPK_DEPTH-1:0] taken;

  // scoring datapath
  logic [7:0]  doc_len;
  logic [qlts_pkg::TweetW-1:0] doc_tweet;
  logic [NW-1:0] s;
  logic [qlts_pkg::LnRW-1:0] ln_mu;
  logic signed [SW-1:0] len_part;
  logic signed [SW-1:0] sum;
  logic [48:0] b_val;
  logic [48:0] t_val;
  logic signed [qlts_pkg::ScoreW-1:0] score;

  // log unit
  logic ln_go;
  logic [qlts_pkg::LnXW-1:0] ln_x;
  logic ln_done;
  logic [qlts_pkg::LnRW-1:0] ln_res;

  // store scan
  logic [CW-1:0] rd_cnt;
  logic          pend;
  logic [AW-1:0] pend_idx;
  logic          have;
  logic signed [qlts_pkg::ScoreW-1:0] best_sc;
  logic [AW-1:0] best_idx;
  logic [qlts_pkg::TweetW-1:0] best_tw;

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [qlts_pkg::MemW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [qlts_pkg::MemW-1:0] mem_rdata;

  // combinational helpers
  logic in_xfer, out_xfer, tok_acc, scored, skipped;
  logic [NW-1:0] n_eff;
  logic [15:0] mu_eff;
  logic [QW-1:0] s_idx;
  logic [CW-1:0] scan_lim;
  logic scan_end;
  logic rd_take;
  logic signed [qlts_pkg::ScoreW-1:0] rd_sc;
  logic signed [SW-1:0] rnd;
  logic signed [SW-1:0] shifted;
  logic signed [qlts_pkg::ScoreW-1:0] sat;
  logic kept_full;
  logic hit_clear;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == qlts_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign tok_acc   = in_xfer && (operation == qlts_pkg::OP_TOKEN);
  assign scored    = tok_acc && last_token && (tweet_id <= time_cutoff);
  assign skipped   = tok_acc && last_token && (tweet_id > time_cutoff);
  assign mu_eff    = (smoothing_mu == 16'd0) ? 16'd1 : smoothing_mu;
  assign n_eff     = (7'(term_count) > 7'(MAX_QUERY_TERMS)) ? NW'(MAX_QUERY_TERMS)
                                                            : NW'(term_count);
  assign s_idx     = s[QW-1:0];
  assign kept_full = (kept == CW'(TOPK_DEPTH));
  assign scan_lim  = (state == qlts_pkg::ST_KSCAN) ? CW'(TOPK_DEPTH) : cnt;
  assign scan_end  = !pend && (rd_cnt == scan_lim);
  assign rd_sc     = $signed(mem_rdata[qlts_pkg::MemW-1:qlts_pkg::TweetW]);
  assign rd_take   = pend && !((state == qlts_pkg::ST_DSCAN) && taken[pend_idx]) &&
                     (!have || (rd_sc < best_sc));
  assign mem_raddr = rd_cnt[AW-1:0];

  // round Q.32 to Q.16, half up, then saturate
  always_comb begin
    rnd     = sum + SW'(32768);
    shifted = rnd >>> 16;
    if (shifted > SW'(64'sd2147483647))
      sat = 32'sh7FFFFFFF;
    else if (shifted < SW'(-64'sd2147483648))
      sat = 32'sh80000000;
    else
      sat = shifted[qlts_pkg::ScoreW-1:0];
  end

  // store writes: append positive scores while filling, replace the minimum when full and beaten
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = kept[AW-1:0];
    mem_wdata = {score, doc_tweet};
    if (state == qlts_pkg::ST_ROUND) begin
      mem_wdata = {sat, doc_tweet};
      mem_we    = (sat > 32'sd0) && !kept_full;
    end else if (state == qlts_pkg::ST_KSCAN && scan_end) begin
      mem_waddr = best_idx;
      mem_we    = score > best_sc;
    end
  end

  always_comb begin
    state_next = state;
    hit_clear  = skipped;
    case (state)
      qlts_pkg::ST_IDLE: begin
        if (scored)
          state_next = qlts_pkg::ST_LNMU;
        else if (in_xfer && operation == qlts_pkg::OP_DRAIN && kept != '0)
          state_next = qlts_pkg::ST_DSCAN;
      end
      qlts_pkg::ST_LNMU:  if (ln_done) state_next = qlts_pkg::ST_LNLEN;
      qlts_pkg::ST_LNLEN: if (ln_done) state_next = qlts_pkg::ST_SLOT;
      qlts_pkg::ST_SLOT: begin
        if (s == n_eff)
          state_next = qlts_pkg::ST_ROUND;
        else if (hit[s_idx] != 8'd0)
          state_next = qlts_pkg::ST_ADD;
      end
      qlts_pkg::ST_ADD:   state_next = qlts_pkg::ST_LNA;
      qlts_pkg::ST_LNA:   if (ln_done) state_next = qlts_pkg::ST_LNB;
      qlts_pkg::ST_LNB:   if (ln_done) state_next = qlts_pkg::ST_SLOT;
      qlts_pkg::ST_ROUND: begin
        if (sat > 32'sd0 && kept_full) begin
          state_next = qlts_pkg::ST_KSCAN;
        end else begin
          state_next = qlts_pkg::ST_IDLE;
          hit_clear  = 1'b1;
        end
      end
      qlts_pkg::ST_KSCAN: begin
        if (scan_end) begin
          state_next = qlts_pkg::ST_IDLE;
          hit_clear  = 1'b1;
        end
      end
      qlts_pkg::ST_DSCAN: if (scan_end) state_next = qlts_pkg::ST_DWAIT;
      qlts_pkg::ST_DWAIT: begin
        if (out_xfer)
          state_next = last_result ? qlts_pkg::ST_IDLE : qlts_pkg::ST_DSCAN;
      end
      default: state_next = qlts_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= qlts_pkg::ST_IDLE;
      time_cutoff      <= 63'h7FFFFFFFFFFFFFFF;
      smoothing_mu     <= 16'd2500;
      collection_terms <= 40'd1;
      term_count       <= 5'd1;
      kept             <= '0;
      taken            <= '0;
      out_valid        <= 1'b0;
      ln_go            <= 1'b0;
      for (int i = 0; i < MAX_QUERY_TERMS; i++) hit[i] <= 8'd0;
    end else begin
      state <= state_next;
      ln_go <= ((state == qlts_pkg::ST_IDLE) && scored) ||
               ((state == qlts_pkg::ST_LNMU) && ln_done) ||
               (state == qlts_pkg::ST_ADD) ||
               ((state == qlts_pkg::ST_LNA) && ln_done);

      if (cfg_valid) begin
        case (cfg_index)
          qlts_pkg::CFG_CUTOFF: time_cutoff      <= cfg_data[62:0];
          qlts_pkg::CFG_MU:     smoothing_mu     <= cfg_data[15:0];
          qlts_pkg::CFG_TOTAL:  collection_terms <= cfg_data[39:0];
          qlts_pkg::CFG_TERMS:  term_count       <= cfg_data[4:0];
          default: ;
        endcase
      end

      for (int i = 0; i < MAX_QUERY_TERMS; i++) begin
        if (hit_clear)
          hit[i] <= 8'd0;
        else if (tok_acc && (NW'(i) < n_eff) && (q_term[i] == term_id) && (hit[i] != 8'hFF))
          hit[i] <= hit[i] + 8'd1;
      end

      if (mem_we && state == qlts_pkg::ST_ROUND) kept <= kept + CW'(1);

      if (state == qlts_pkg::ST_IDLE && in_xfer && operation == qlts_pkg::OP_DRAIN) begin
        taken <= '0;
        if (kept == '0) kept <= '0;
      end
      if (state == qlts_pkg::ST_DSCAN && scan_end) begin
        taken[best_idx] <= 1'b1;
        out_valid       <= 1'b1;
      end
      if (state == qlts_pkg::ST_DWAIT && out_xfer) begin
        out_valid <= 1'b0;
        if (last_result) kept <= '0;
      end
    end
  end

  // query table (payload, no reset)
  always_ff @(posedge clk) begin
    if (in_xfer && operation == qlts_pkg::OP_LOAD && (7'(slot) < 7'(MAX_QUERY_TERMS))) begin
      q_term[QW'(slot)] <= term_id;
      q_freq[QW'(slot)] <= collection_freq;
    end
  end

  // scoring and scan datapath
  always_ff @(posedge clk) begin
    case (state)
      qlts_pkg::ST_IDLE: begin
        doc_len   <= doc_length;
        doc_tweet <= tweet_id;
        ln_x      <= qlts_pkg::LnXW'(mu_eff);
        cnt       <= kept;
        r         <= '0;
        rd_cnt    <= '0;
        pend      <= 1'b0;
        have      <= 1'b0;
      end
      qlts_pkg::ST_LNMU: begin
        if (ln_done) begin
          ln_mu <= ln_res;
          ln_x  <= qlts_pkg::LnXW'(17'(doc_len) + 17'(mu_eff));
        end
      end
      qlts_pkg::ST_LNLEN: begin
        if (ln_done) begin
          len_part <= SW'(ln_mu) - SW'(ln_res);
          sum      <= '0;
          s        <= '0;
        end
      end
      qlts_pkg::ST_SLOT: begin
        b_val <= 49'(mu_eff) * (49'(q_freq[s_idx]) + 49'd1);
        t_val <= 49'(hit[s_idx]) * (49'(collection_terms) + 49'd1);
        if (s != n_eff && hit[s_idx] == 8'd0) s <= s + NW'(1);
      end
      qlts_pkg::ST_ADD: ln_x <= qlts_pkg::LnXW'(b_val) + qlts_pkg::LnXW'(t_val);
      qlts_pkg::ST_LNA: begin
        if (ln_done) begin
          sum  <= sum + SW'(ln_res) + len_part;
          ln_x <= qlts_pkg::LnXW'(b_val);
        end
      end
      qlts_pkg::ST_LNB: begin
        if (ln_done) begin
          sum <= sum - SW'(ln_res);
          s   <= s + NW'(1);
        end
      end
      qlts_pkg::ST_ROUND: begin
        score  <= sat;
        rd_cnt <= '0;
        pend   <= 1'b0;
        have   <= 1'b0;
      end
      qlts_pkg::ST_KSCAN, qlts_pkg::ST_DSCAN: begin
        pend     <= (rd_cnt != scan_lim);
        pend_idx <= rd_cnt[AW-1:0];
        if (rd_cnt != scan_lim) rd_cnt <= rd_cnt + CW'(1);
        if (rd_take) begin
          have     <= 1'b1;
          best_sc  <= rd_sc;
          best_idx <= pend_idx;
          best_tw  <= mem_rdata[qlts_pkg::TweetW-1:0];
        end
        if (state == qlts_pkg::ST_DSCAN && scan_end) begin
          result_tweet <= best_tw;
          result_score <= best_sc;
          rank         <= qlts_pkg::RankW'(TOPK_DEPTH) - qlts_pkg::RankW'(r);
          last_result  <= (CW'(r + CW'(1)) == cnt);
        end
      end
      qlts_pkg::ST_DWAIT: begin
        if (out_xfer) begin
          r      <= r + CW'(1);
          rd_cnt <= '0;
          pend   <= 1'b0;
          have   <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  qlts_ln u_ln (
    .clk    (clk),
    .rst    (rst),
    .start  (ln_go),
    .x      (ln_x),
    .done   (ln_done),
    .result (ln_res)
  );

  qlts_mem #(
    .DEPTH (TOPK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== rtl/core/qlts_ln.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlts_ln: iterative natural logarithm
// Normalizes one bit per cycle, then takes 24 log2 fraction bits by
// repeated squaring, then scales by ln 2. Result is unsigned Q.32.
// ----------------------------------------------------------------------------
module qlts_ln (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [qlts_pkg::LnXW-1:0] x,
  output logic                      done,
  output logic [qlts_pkg::LnRW-1:0] result
);

  qlts_pkg::ln_state_t state, state_next;

  logic [qlts_pkg::LnXW-1:0] m;
  logic [5:0]  k;
  logic [23:0] frac;
  logic [4:0]  cnt;

  logic [63:0] sq;
  logic [32:0] sq_hi;
  logic [61:0] prod;
  logic [61:0] prod_rnd;
  logic        above;

  always_comb begin
    sq       = 64'(m[31:0]) * 64'(m[31:0]);
    sq_hi    = sq[63:31];
    prod     = 62'({k, frac}) * 62'(qlts_pkg::LN2_Q32);
    prod_rnd = prod + 62'(24'h800000);
    above    = |m[qlts_pkg::LnXW-1:32];
  end

  always_comb begin
    state_next = state;
    case (state)
      qlts_pkg::LN_IDLE: if (start) state_next = qlts_pkg::LN_NORM;
      qlts_pkg::LN_NORM: if (!above && m[31]) state_next = qlts_pkg::LN_SQ;
      qlts_pkg::LN_SQ:   if (cnt == 5'd23) state_next = qlts_pkg::LN_MUL;
      qlts_pkg::LN_MUL:  state_next = qlts_pkg::LN_IDLE;
      default:           state_next = qlts_pkg::LN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qlts_pkg::LN_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == qlts_pkg::LN_MUL);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      qlts_pkg::LN_IDLE: begin
        m <= x;
        k <= 6'd31;
      end
      qlts_pkg::LN_NORM: begin
        if (above) begin
          m <= m >> 1;
          k <= k + 6'd1;
        end else if (!m[31]) begin
          m <= m << 1;
          k <= k - 6'd1;
        end
        cnt  <= 5'd0;
        frac <= 24'd0;
      end
      qlts_pkg::LN_SQ: begin
        // square of Q1.31 mantissa; a carry past 2 means log bit set
        if (sq_hi[32]) begin
          m    <= qlts_pkg::LnXW'(sq_hi[32:1]);
          frac <= {frac[22:0], 1'b1};
        end else begin
          m    <= qlts_pkg::LnXW'(sq_hi[31:0]);
          frac <= {frac[22:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
      end
      qlts_pkg::LN_MUL: result <= prod_rnd[61:24];
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/qlts_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlts_mem: top-K result store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module qlts_mem #(
  parameter int DEPTH = qlts_pkg::TopkDepthDef,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [qlts_pkg::MemW-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [qlts_pkg::MemW-1:0] rdata
);

  logic [qlts_pkg::MemW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
